@@ rtl/core/ictf_pkg.sv @@
// Shared widths, constants and helper functions for the complementary tilt filter.
// Used by every module under rtl/core.
package ictf_pkg;

    localparam int DVD_W        = 53;
    localparam int DEN_W        = 27;
    localparam int DIV_CNT_W    = $clog2(DVD_W + 1);
    localparam int GYRO_DEN     = 131000000;
    localparam int GYRO_HALF    = 65500000;
    localparam int NUDGE_DEN    = 1000;
    localparam int NUDGE_HALF   = 500;
    localparam int NUDGE_LIMIT  = 2500;
    localparam int STICK_CENTRE = 50;
    localparam int BLEND_RESET  = 62915;

    localparam int SQRT_ITER    = 32;
    localparam int SQRT_CNT_W   = $clog2(SQRT_ITER + 1);

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int CORDIC_ITER  = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    localparam int CORDIC_CNT_W = $clog2(ATAN_ENTRIES + 1);
    localparam int CORDIC_W     = 36;

    typedef enum logic [1:0] {
        REG_GYRO_X_BIAS = 2'd0,
        REG_GYRO_Y_BIAS = 2'd1,
        REG_GYRO_Z_BIAS = 2'd2,
        REG_BLEND_WEIGHT = 2'd3
    } t_reg_idx;

    function automatic logic signed [31:0] atan_deg(input logic [CORDIC_CNT_W-1:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:    v = 32'sd2949120;
            5'd1:    v = 32'sd1740967;
            5'd2:    v = 32'sd919879;
            5'd3:    v = 32'sd466945;
            5'd4:    v = 32'sd234379;
            5'd5:    v = 32'sd117304;
            5'd6:    v = 32'sd58666;
            5'd7:    v = 32'sd29335;
            5'd8:    v = 32'sd14668;
            5'd9:    v = 32'sd7334;
            5'd10:   v = 32'sd3667;
            5'd11:   v = 32'sd1833;
            5'd12:   v = 32'sd917;
            5'd13:   v = 32'sd458;
            5'd14:   v = 32'sd229;
            5'd15:   v = 32'sd115;
            5'd16:   v = 32'sd57;
            5'd17:   v = 32'sd29;
            5'd18:   v = 32'sd14;
            5'd19:   v = 32'sd7;
            5'd20:   v = 32'sd4;
            5'd21:   v = 32'sd2;
            5'd22:   v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sh007FFFFFFF) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -40'sh0080000000) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/ictf_if.sv @@
// Handshake channel interfaces for samples, results and register writes.
// Depends on nothing but plain logic types.
interface ictf_sample_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  accel_x;
    logic signed [15:0]  accel_y;
    logic signed [15:0]  accel_z;
    logic signed [15:0]  rate_x;
    logic signed [15:0]  rate_y;
    logic signed [15:0]  rate_z;
    logic        [19:0]  elapsed_us;
    logic        [6:0]   stick_x;
    logic        [6:0]   stick_y;
    modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                    elapsed_us, stick_x, stick_y, input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                  elapsed_us, stick_x, stick_y, output ready);
endinterface

interface ictf_result_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  roll_angle;
    logic signed [31:0]  pitch_angle;
    logic signed [31:0]  yaw_angle;
    logic                tilt_held;
    modport source (output valid, roll_angle, pitch_angle, yaw_angle, tilt_held, input ready);
    modport sink (input valid, roll_angle, pitch_angle, yaw_angle, tilt_held, output ready);
endinterface

interface ictf_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/ictf_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on ictf_pkg for its widths.
module ictf_div import ictf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DEN_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0]     r_sh;
    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     r_den;
    logic [DEN_W:0]       n_cur;
    logic                 n_qbit;

    assign n_cur  = {r_rem, r_sh[DVD_W-1]};
    assign n_qbit = (n_cur >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_sh   <= i_dividend;
            r_rem  <= '0;
            r_den  <= i_divisor;
        end else if (r_busy) begin
            r_sh   <= {r_sh[DVD_W-2:0], n_qbit};
            r_rem  <= n_qbit ? DEN_W'(n_cur - {1'b0, r_den}) : n_cur[DEN_W-1:0];
            r_cnt  <= r_cnt + 1'b1;
            r_done <= (r_cnt == DIV_CNT_W'(DVD_W - 1));
            if (r_cnt == DIV_CNT_W'(DVD_W - 1)) begin
                r_busy <= 1'b0;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_sh;
endmodule

@@ rtl/core/ictf_sqrt.sv @@
// Digit-serial floor square root, two radicand bits per cycle.
// Depends on ictf_pkg for its iteration count.
module ictf_sqrt import ictf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_radicand,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic                  r_busy;
    logic                  r_done;
    logic [SQRT_CNT_W-1:0] r_cnt;
    logic [63:0]           r_rad;
    logic [33:0]           r_rem;
    logic [31:0]           r_root;
    logic [35:0]           n_cur;
    logic [35:0]           n_trial;
    logic                  n_bit;

    assign n_cur   = {r_rem, r_rad[63:62]};
    assign n_trial = {2'b00, r_root, 2'b01};
    assign n_bit   = (n_cur >= n_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[61:0], 2'b00};
            r_rem  <= n_bit ? 34'(n_cur - n_trial) : n_cur[33:0];
            r_root <= {r_root[30:0], n_bit};
            r_cnt  <= r_cnt + 1'b1;
            r_done <= (r_cnt == SQRT_CNT_W'(SQRT_ITER - 1));
            if (r_cnt == SQRT_CNT_W'(SQRT_ITER - 1)) begin
                r_busy <= 1'b0;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

@@ rtl/core/ictf_cordic.sv @@
// Vectoring CORDIC, one rotation per cycle, giving the angle in Q16.16 degrees.
// Depends on ictf_pkg for the arctangent table and step count.
module ictf_cordic import ictf_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [CORDIC_W-1:0] i_x,
    input  logic signed [CORDIC_W-1:0] i_y,
    output logic                       o_done,
    output logic signed [31:0]         o_angle
);
    logic                       r_busy;
    logic                       r_done;
    logic [CORDIC_CNT_W-1:0]    r_cnt;
    logic signed [CORDIC_W-1:0] r_x;
    logic signed [CORDIC_W-1:0] r_y;
    logic signed [31:0]         r_z;
    logic signed [CORDIC_W-1:0] n_dx;
    logic signed [CORDIC_W-1:0] n_dy;

    assign n_dx = r_y >>> r_cnt;
    assign n_dy = r_x >>> r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_x    <= i_x;
            r_y    <= i_y;
            r_z    <= '0;
        end else if (r_busy) begin
            if (r_y > 0) begin
                r_x <= r_x + n_dx;
                r_y <= r_y - n_dy;
                r_z <= r_z + atan_deg(r_cnt);
            end else begin
                r_x <= r_x - n_dx;
                r_y <= r_y + n_dy;
                r_z <= r_z - atan_deg(r_cnt);
            end
            r_cnt  <= r_cnt + 1'b1;
            r_done <= (r_cnt == CORDIC_CNT_W'(CORDIC_ITER - 1));
            if (r_cnt == CORDIC_CNT_W'(CORDIC_ITER - 1)) begin
                r_busy <= 1'b0;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_z;
endmodule

@@ rtl/core/imu_complementary_tilt_filter.sv @@
// Top level of the complementary tilt filter: sequencer, state and output register.
// Depends on ictf_pkg, the channel interfaces, ictf_div, ictf_sqrt and ictf_cordic.
//
//  Channel    Direction  Carries
//  i_sample   in         accelerometer, gyro, elapsed time, joystick levels
//  o_result   out        roll, pitch and yaw in Q16.16 degrees, tilt hold flag
//  i_cfg      in         register index and write data
//
// A sample runs five bit-serial divisions, then a square root and a CORDIC run for each
// of the two tilt angles. The serial divider takes most of the time per sample.
// Reset is synchronous and active low; it clears the angles and joystick sums.
// A new sample is taken while a finished result still waits on o_result.
module imu_complementary_tilt_filter import ictf_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ictf_sample_if.sink    i_sample,
    ictf_result_if.source  o_result,
    ictf_cfg_if.sink       i_cfg
);
    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_DSTART, S_DWAIT, S_SQA, S_SQB, S_SSTART, S_SWAIT,
        S_CSTART, S_CWAIT, S_BM1, S_BM2, S_BSUM, S_FIN
    } t_state;

    t_state              r_state;
    logic signed [15:0]  r_bias_x, r_bias_y, r_bias_z;
    logic [15:0]         r_weight;
    logic signed [31:0]  r_prev_roll, r_prev_pitch, r_prev_yaw;
    logic signed [12:0]  r_nx, r_ny;
    logic signed [15:0]  r_ax, r_ay, r_az, r_gx, r_gy, r_gz;
    logic [19:0]         r_us;
    logic                r_held;
    logic [2:0]          r_job;
    logic                r_t;
    logic signed [37:0]  r_prod;
    logic signed [27:0]  r_step [5];
    logic [31:0]         r_sq;
    logic [31:0]         r_sum;
    logic [31:0]         r_root;
    logic signed [31:0]  r_tilt0, r_tilt1;
    logic signed [51:0]  r_p1;
    logic signed [49:0]  r_p2;
    logic signed [31:0]  r_rb;
    logic signed [39:0]  r_pb;
    logic                r_ovalid;
    logic signed [31:0]  r_oroll, r_opitch, r_oyaw;
    logic                r_oheld;

    logic signed [16:0]  n_rate;
    logic signed [37:0]  n_prod;
    logic [37:0]         n_mag;
    logic [DVD_W-1:0]    n_dividend;
    logic [DEN_W-1:0]    n_divisor;
    logic signed [15:0]  n_sa, n_sb;
    logic signed [16:0]  n_num;
    logic signed [33:0]  n_g;
    logic signed [31:0]  n_tilt;
    logic signed [52:0]  n_bsum;
    logic signed [39:0]  n_bfull;
    logic signed [31:0]  n_blend;
    logic signed [12:0]  n_nx, n_ny;
    logic signed [31:0]  n_pitch, n_yaw;

    logic                div_done, sqrt_done, cor_done;
    logic [DVD_W-1:0]    div_q;
    logic [31:0]         sqrt_root;
    logic signed [31:0]  cor_angle;

    always_comb begin
        case (r_job)
            3'd0:    n_rate = 17'(r_gx) - 17'(r_bias_x);
            3'd1:    n_rate = 17'(r_gy) - 17'(r_bias_y);
            default: n_rate = 17'(r_gz) - 17'(r_bias_z);
        endcase
        case (r_job)
            3'd3:    n_prod = 38'(r_nx);
            3'd4:    n_prod = 38'(r_ny);
            default: n_prod = 38'(n_rate * $signed({1'b0, r_us}));
        endcase
    end

    assign n_mag      = r_prod[37] ? 38'(-r_prod) : r_prod;
    assign n_dividend = DVD_W'({n_mag[35:0], 16'h0000})
                      + ((r_job < 3'd3) ? DVD_W'(GYRO_HALF) : DVD_W'(NUDGE_HALF));
    assign n_divisor  = (r_job < 3'd3) ? DEN_W'(GYRO_DEN) : DEN_W'(NUDGE_DEN);

    assign n_sa   = r_t ? r_ay : r_ax;
    assign n_sb   = r_az;
    assign n_num  = r_t ? 17'(-17'(r_ax)) : 17'(r_ay);
    assign n_g    = r_t ? 34'(r_prev_pitch) + 34'(r_step[1])
                        : 34'(r_prev_roll) + 34'(r_step[0]);
    assign n_tilt = r_t ? r_tilt1 : r_tilt0;
    assign n_bsum = 53'(r_p1) + 53'(r_p2) + 53'sd32768;
    assign n_bfull = 40'(n_bsum >>> 16);
    assign n_blend = sat32(n_bfull);

    assign n_nx = (r_nx > 13'sd2500) ? 13'(NUDGE_LIMIT)
                : (r_nx < -13'sd2500) ? -13'(NUDGE_LIMIT) : r_nx;
    assign n_ny = (r_ny > 13'sd2500) ? 13'(NUDGE_LIMIT)
                : (r_ny < -13'sd2500) ? -13'(NUDGE_LIMIT) : r_ny;
    assign n_pitch = sat32(r_pb + 40'(r_step[3]));
    assign n_yaw   = sat32(40'(r_prev_yaw) + 40'(r_step[2]) + 40'(r_step[4]));

    ictf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DSTART),
        .i_dividend (n_dividend),
        .i_divisor  (n_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    ictf_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_SSTART),
        .i_radicand ({r_sum, 32'h0}),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    ictf_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_CSTART),
        .i_x     ($signed(CORDIC_W'(r_root))),
        .i_y     (CORDIC_W'($signed({n_num, 16'h0000}))),
        .o_done  (cor_done),
        .o_angle (cor_angle)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_bias_x     <= '0;
            r_bias_y     <= '0;
            r_bias_z     <= '0;
            r_weight     <= 16'(BLEND_RESET);
            r_prev_roll  <= '0;
            r_prev_pitch <= '0;
            r_prev_yaw   <= '0;
            r_nx         <= '0;
            r_ny         <= '0;
            r_job        <= '0;
            r_t          <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (t_reg_idx'(i_cfg.index))
                    REG_GYRO_X_BIAS:  r_bias_x <= $signed(i_cfg.data);
                    REG_GYRO_Y_BIAS:  r_bias_y <= $signed(i_cfg.data);
                    REG_GYRO_Z_BIAS:  r_bias_z <= $signed(i_cfg.data);
                    REG_BLEND_WEIGHT: r_weight <= i_cfg.data;
                    default:          r_weight <= r_weight;
                endcase
            end
            if (o_result.ready && (r_state != S_FIN)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_sample.valid) begin
                        r_ax   <= i_sample.accel_x;
                        r_ay   <= i_sample.accel_y;
                        r_az   <= i_sample.accel_z;
                        r_gx   <= i_sample.rate_x;
                        r_gy   <= i_sample.rate_y;
                        r_gz   <= i_sample.rate_z;
                        r_us   <= i_sample.elapsed_us;
                        r_held <= (i_sample.accel_x == 16'sd0) && (i_sample.accel_y == 16'sd0)
                                  && (i_sample.accel_z == 16'sd0);
                        r_nx   <= r_nx + 13'($signed({1'b0, i_sample.stick_x}))
                                  - 13'(STICK_CENTRE);
                        r_ny   <= r_ny + 13'($signed({1'b0, i_sample.stick_y}))
                                  - 13'(STICK_CENTRE);
                        r_job  <= '0;
                        r_t    <= 1'b0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= n_prod;
                    r_state <= S_DSTART;
                end
                S_DSTART: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (div_done) begin
                        r_step[r_job] <= r_prod[37] ? 28'(-$signed({1'b0, div_q[26:0]}))
                                                    : $signed({1'b0, div_q[26:0]});
                        if (r_job == 3'd4) begin
                            r_state <= S_SQA;
                        end else begin
                            r_job   <= r_job + 3'd1;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_SQA: begin
                    r_sq    <= 32'(n_sa * n_sa);
                    r_state <= S_SQB;
                end
                S_SQB: begin
                    r_sum   <= r_sq + 32'(n_sb * n_sb);
                    r_state <= S_SSTART;
                end
                S_SSTART: r_state <= S_SWAIT;
                S_SWAIT: begin
                    if (sqrt_done) begin
                        r_root  <= sqrt_root;
                        r_state <= S_CSTART;
                    end
                end
                S_CSTART: r_state <= S_CWAIT;
                S_CWAIT: begin
                    if (cor_done) begin
                        if (r_t) begin
                            r_tilt1 <= cor_angle;
                            r_t     <= 1'b0;
                            r_state <= S_BM1;
                        end else begin
                            r_tilt0 <= cor_angle;
                            r_t     <= 1'b1;
                            r_state <= S_SQA;
                        end
                    end
                end
                S_BM1: begin
                    r_p1    <= 52'($signed({2'b00, r_weight}) * n_g);
                    r_state <= S_BM2;
                end
                S_BM2: begin
                    r_p2    <= 50'($signed({1'b0, 17'(18'sd65536 - $signed({2'b00, r_weight}))})
                                   * n_tilt);
                    r_state <= S_BSUM;
                end
                S_BSUM: begin
                    if (r_t) begin
                        r_pb    <= n_bfull;
                        r_state <= S_FIN;
                    end else begin
                        r_rb    <= n_blend;
                        r_t     <= 1'b1;
                        r_state <= S_BM1;
                    end
                end
                S_FIN: begin
                    if (!r_ovalid || o_result.ready) begin
                        if (!r_held) begin
                            r_prev_roll  <= r_rb;
                            r_prev_pitch <= n_pitch;
                            r_oroll      <= r_rb;
                            r_opitch     <= n_pitch;
                        end else begin
                            r_oroll      <= r_prev_roll;
                            r_opitch     <= r_prev_pitch;
                        end
                        r_prev_yaw <= n_yaw;
                        r_oyaw     <= n_yaw;
                        r_oheld    <= r_held;
                        r_nx       <= n_nx;
                        r_ny       <= n_ny;
                        r_ovalid   <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_sample.ready       = (r_state == S_IDLE);
    assign i_cfg.ready          = 1'b1;
    assign o_result.valid       = r_ovalid;
    assign o_result.roll_angle  = r_oroll;
    assign o_result.pitch_angle = r_opitch;
    assign o_result.yaw_angle   = r_oyaw;
    assign o_result.tilt_held   = r_oheld;
endmodule

@@ tb/sv/tb_pkg.sv @@
`timescale 1ns / 1ps
// Shared types for the tilt filter testbench: one sample request and one angle result.
// Depends on no other package.
package tb_pkg;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
        logic        [19:0] elapsed_us;
        logic        [6:0]  stick_x;
        logic        [6:0]  stick_y;
    } t_sample;

    typedef struct packed {
        logic signed [31:0] roll;
        logic signed [31:0] pitch;
        logic signed [31:0] yaw;
        logic               held;
    } t_angles;

endpackage

@@ tb/sv/tb_checker.sv @@
`timescale 1ns / 1ps
// Attitude checker: watches the sample, result and register channels, predicts angles
// and compares them in order. Depends on ictf_pkg, tb_pkg and the channel interfaces.
module tb_checker import ictf_pkg::*; import tb_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ictf_sample_if i_sample,
    ictf_result_if i_result,
    ictf_cfg_if    i_cfg,
    output int     o_errors,
    output int     o_pending
);

    longint bias_x, bias_y, bias_z, weight;
    longint last_roll, last_pitch, last_yaw, push_x, push_y;
    t_angles expected_angles[$];
    longint atan_table[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

    function automatic longint floor_shift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint round_div(longint num, longint den);
        longint mag;
        mag = num < 0 ? -num : num;
        mag = (mag + den / 2) / den;
        return num < 0 ? -mag : mag;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint root_floor(logic [63:0] v);
        logic [63:0] res, bit_w;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return longint'(res);
    endfunction

    function automatic longint tilt_deg(longint num, longint a, longint b);
        logic [63:0] sum;
        longint x, y, z, dx, dy;
        sum = (a * a) + (b * b);
        x = root_floor(sum << 32);
        y = num * 65536;
        z = 0;
        for (int i = 0; i < CORDIC_ITER; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y > 0) begin
                x += dx; y -= dy; z += atan_table[i];
            end else begin
                x -= dx; y += dy; z -= atan_table[i];
            end
        end
        return z;
    endfunction

    function automatic longint gyro_delta(longint raw, longint bias, longint us);
        return round_div((raw - bias) * us * 65536, 131000000);
    endfunction

    function automatic longint mix(longint gyro, longint tilt);
        return floor_shift(weight * gyro + (65536 - weight) * tilt + 32768, 16);
    endfunction

    function automatic longint limit_push(longint v);
        if (v > 2500) return 2500;
        if (v < -2500) return -2500;
        return v;
    endfunction

    function automatic t_angles predict_angles(t_sample s);
        t_angles r;
        longint ax, ay, az, us;
        ax = s.accel_x; ay = s.accel_y; az = s.accel_z; us = s.elapsed_us;
        r.held = (ax == 0 && ay == 0 && az == 0);
        push_x += longint'(s.stick_x) - 50;
        push_y += longint'(s.stick_y) - 50;
        last_yaw = clip32(last_yaw + gyro_delta(s.rate_z, bias_z, us)
                          + round_div(push_y * 65536, 1000));
        if (!r.held) begin
            last_roll = clip32(mix(last_roll + gyro_delta(s.rate_x, bias_x, us),
                                   tilt_deg(ay, ax, az)));
            last_pitch = clip32(mix(last_pitch + gyro_delta(s.rate_y, bias_y, us),
                                    tilt_deg(-ax, ay, az))
                                + round_div(push_x * 65536, 1000));
        end
        push_x = limit_push(push_x);
        push_y = limit_push(push_y);
        r.roll = last_roll[31:0];
        r.pitch = last_pitch[31:0];
        r.yaw = last_yaw[31:0];
        return r;
    endfunction

    assign o_pending = expected_angles.size();

    always @(posedge i_clk) begin
        t_angles got, want;
        t_sample s;
        if (!i_rst_n) begin
            bias_x = 0; bias_y = 0; bias_z = 0; weight = BLEND_RESET;
            last_roll = 0; last_pitch = 0; last_yaw = 0; push_x = 0; push_y = 0;
            expected_angles.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_reg_idx'(i_cfg.index))
                    REG_GYRO_X_BIAS:  bias_x = longint'($signed(i_cfg.data));
                    REG_GYRO_Y_BIAS:  bias_y = longint'($signed(i_cfg.data));
                    REG_GYRO_Z_BIAS:  bias_z = longint'($signed(i_cfg.data));
                    REG_BLEND_WEIGHT: weight = longint'(i_cfg.data);
                endcase
            end
            if (i_sample.valid && i_sample.ready) begin
                s = '{i_sample.accel_x, i_sample.accel_y, i_sample.accel_z,
                      i_sample.rate_x, i_sample.rate_y, i_sample.rate_z,
                      i_sample.elapsed_us, i_sample.stick_x, i_sample.stick_y};
                expected_angles.push_back(predict_angles(s));
            end
            if (i_result.valid && i_result.ready) begin
                got = '{i_result.roll_angle, i_result.pitch_angle, i_result.yaw_angle,
                        i_result.tilt_held};
                if (expected_angles.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_angles.pop_front();
                    if (got.roll !== want.roll)
                        $display("%0t: roll expected %0d actual %0d", $time, want.roll,
                                 got.roll);
                    if (got.pitch !== want.pitch)
                        $display("%0t: pitch expected %0d actual %0d", $time, want.pitch,
                                 got.pitch);
                    if (got.yaw !== want.yaw)
                        $display("%0t: yaw expected %0d actual %0d", $time, want.yaw,
                                 got.yaw);
                    if (got.held !== want.held)
                        $display("%0t: tilt_held expected %0b actual %0b", $time,
                                 want.held, got.held);
                    if (got !== want) o_errors <= o_errors + 1;
                end
            end
        end
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the complementary tilt filter: clock, reset, register writes and
// sample requests with random idling. Depends on ictf_pkg, tb_pkg, interfaces, tb_checker.
module tb import ictf_pkg::*; import tb_pkg::*; ();

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int errors, pending;
    int send_idle = 0, take_idle = 0;
    bit hold_off = 0;

    ictf_sample_if sample_ch();
    ictf_result_if result_ch();
    ictf_cfg_if cfg_ch();

    imu_complementary_tilt_filter dut (.i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_sample(sample_ch.sink), .o_result(result_ch.source), .i_cfg(cfg_ch.sink));

    tb_checker chk (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_sample(sample_ch),
        .i_result(result_ch), .i_cfg(cfg_ch), .o_errors(errors), .o_pending(pending));

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #400ms;
        $display("Verification failed");
        $finish;
    end

    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            result_ch.ready <= !hold_off && ($urandom_range(99) >= take_idle);
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_sample(t_sample s);
        while ($urandom_range(99) < send_idle) begin
            sample_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        {sample_ch.accel_x, sample_ch.accel_y, sample_ch.accel_z, sample_ch.rate_x,
         sample_ch.rate_y, sample_ch.rate_z, sample_ch.elapsed_us, sample_ch.stick_x,
         sample_ch.stick_y} <= s;
        sample_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!sample_ch.ready);
    endtask

    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    function automatic t_sample random_sample();
        t_sample s;
        s = t_sample'($bits(t_sample)'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        case ($urandom_range(9))
            0: s.elapsed_us = 20'($urandom);
            1, 2: s.elapsed_us = 20'($urandom_range(20000));
            default: s.elapsed_us = 20'($urandom_range(5000, 15000));
        endcase
        if ($urandom_range(9) != 0) begin
            s.rate_x = $signed(16'($urandom_range(4000))) - 16'sd2000;
            s.rate_y = $signed(16'($urandom_range(4000))) - 16'sd2000;
            s.rate_z = $signed(16'($urandom_range(4000))) - 16'sd2000;
            s.stick_x = 7'($urandom_range(100));
            s.stick_y = 7'($urandom_range(100));
        end
        if ($urandom_range(19) == 0) {s.accel_x, s.accel_y, s.accel_z} = '0;
        return s;
    endfunction

    initial begin
        t_sample s;
        sample_ch.valid = 1'b0;
        {sample_ch.accel_x, sample_ch.accel_y, sample_ch.accel_z, sample_ch.rate_x,
         sample_ch.rate_y, sample_ch.rate_z, sample_ch.elapsed_us, sample_ch.stick_x,
         sample_ch.stick_y} = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_GYRO_X_BIAS;
        cfg_ch.data = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests: extremes, undefined tilt, vertical tilt, stick out of range.
        send_sample('0);
        send_sample('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                      20'hFFFFF, 7'd127, 7'd127});
        send_sample('{-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000,
                      -16'sh8000, 20'hFFFFF, 7'd0, 7'd0});
        send_sample('{16'sd0, 16'sd1000, 16'sd0, 16'sd131, -16'sd131, 16'sd0, 20'd10000,
                      7'd100, 7'd0});
        send_sample('{16'sd1000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'd1,
                      7'd50, 7'd50});
        send_sample('{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 20'd0,
                      7'd101, 7'd50});
        send_sample('{16'sd0, 16'sd0, 16'sd0, 16'sd500, 16'sd500, 16'sd500, 20'd20000,
                      7'd80, 7'd20});
        for (int i = 0; i < 6; i++) send_sample('{16'sh7FFF, 16'sd0, 16'sd0, 16'sh7FFF,
            16'sh7FFF, 16'sh7FFF, 20'hFFFFF, 7'd127, 7'd127});
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_GYRO_X_BIAS, 16'h8000);
                    write_reg(REG_GYRO_Y_BIAS, 16'h7FFF);
                    write_reg(REG_GYRO_Z_BIAS, 16'hFFFF);
                    write_reg(REG_BLEND_WEIGHT, 16'h0000);
                    send_idle = 13; take_idle = 57;
                end
                1: begin
                    write_reg(REG_BLEND_WEIGHT, 16'hFFFF);
                    write_reg(REG_GYRO_X_BIAS, 16'h7FFF);
                    write_reg(REG_GYRO_Y_BIAS, 16'h8000);
                    send_idle = 57; take_idle = 13;
                end
                default: begin
                    write_reg(REG_GYRO_X_BIAS, 16'($urandom_range(400) - 200));
                    write_reg(REG_GYRO_Y_BIAS, 16'($urandom_range(400) - 200));
                    write_reg(REG_GYRO_Z_BIAS, 16'($urandom_range(400) - 200));
                    write_reg(REG_BLEND_WEIGHT, 16'($urandom));
                    send_idle = 0; take_idle = 0;
                end
            endcase
            if (phase == 3) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (3000) @(posedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            for (int i = 0; i < 495; i++) send_sample(random_sample());
            drain();
        end

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/ictf_pkg.sv
rtl/core/ictf_if.sv
rtl/core/ictf_div.sv
rtl/core/ictf_sqrt.sv
rtl/core/ictf_cordic.sv
rtl/core/imu_complementary_tilt_filter.sv
tb/sv/tb_pkg.sv
tb/sv/tb_checker.sv
tb/sv/tb.sv
